/* sv/scd_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the segment helper function of the countdown display block.
package scd_pkg;

  localparam int ELAPSED_W       = 32;
  localparam int BLINK_PERIOD_MS = 200;
  localparam int BLINK_W         = $clog2(BLINK_PERIOD_MS);

  localparam int SEC_W    = 16;
  localparam int SPEED_W  = 16;
  localparam int STRIKE_W = 8;
  localparam int MODE_W   = 2;
  localparam int SEG_W    = 7;
  localparam int VAL_W    = 7;
  localparam int DIG_W    = 4;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;

  localparam logic [SEC_W-1:0] NO_TIME  = '1;
  localparam logic [SEG_W-1:0] SEG_DASH = 7'h40;

  localparam int CS_PER_S   = 100;
  localparam int S_PER_MIN  = 60;
  localparam int SS_LIMIT   = 6000;
  localparam int MAX_MIN    = 99;
  localparam int COLON_HALF = 50;
  localparam int RADIX      = 10;

  // elapsed centis = (ms * speed) / 2560, and 2560 = 5 << 9
  localparam int PROD_W    = ELAPSED_W + SPEED_W;
  localparam int PRE_SH    = 9;
  localparam int Q_W       = PROD_W - PRE_SH;
  localparam int QL_W      = 20;
  localparam int QH_W      = Q_W - QL_W;
  localparam int QL_DIV5   = ((1 << QL_W) - 1) / 5;
  localparam int QL_DIV5_W = $clog2(QL_DIV5 + 1);
  localparam int A_W       = QH_W + QL_DIV5_W;
  localparam int CE_W      = Q_W - 2;
  localparam int S_W       = ((QH_W > QL_W) ? QH_W : QL_W) + 1;
  localparam int RCP5_SH   = S_W + 3;
  localparam longint RCP5  = ((longint'(1) << RCP5_SH) + 4) / 5;
  localparam int SD_W      = S_W - 2;

  // centis mod 100 by folding the upper part: 2^CL_W mod 100
  localparam int CL_W      = 20;
  localparam int CH_W      = CE_W - CL_W;
  localparam int FOLD      = (1 << CL_W) % CS_PER_S;
  localparam int X_W       = (((CH_W + 7) > CL_W) ? (CH_W + 7) : CL_W) + 1;
  localparam int RCPX_SH   = X_W + 7;
  localparam longint RCPX  = ((longint'(1) << RCPX_SH) + 99) / 100;
  localparam int Q100X_W   = X_W - 6;

  localparam int TOTAL_W   = SEC_W + 7;
  localparam int CMP_W     = (CE_W > TOTAL_W) ? CE_W : TOTAL_W;
  localparam int RCPL_SH   = TOTAL_W + 7;
  localparam longint RCPL  = ((longint'(1) << RCPL_SH) + 99) / 100;
  localparam int C_W       = TOTAL_W - 6;
  localparam int RCPM_SH   = C_W + 6;
  localparam longint RCPM  = ((longint'(1) << RCPM_SH) + 59) / 60;
  localparam int MIN_W     = C_W - 5;

  localparam int DIV10_RCP = 205;
  localparam int DIV10_SH  = 11;
  localparam int DIV10_W   = VAL_W + 8;

  localparam int TIME_STAGES = 8;
  localparam int PIPE_STAGES = TIME_STAGES + 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_START = 2'd2
  } mode_e;

  typedef struct packed {
    logic                exploded;
    logic                running;
    logic                active;
    logic [STRIKE_W-1:0] load_strikes;
    logic [SPEED_W-1:0]  load_speed;
    logic [SEC_W-1:0]    load_seconds;
  } in_beat_t;

  typedef struct packed {
    logic notime;
    logic exploded;
    logic led1;
    logic led2;
  } flags_t;

  typedef struct packed {
    logic [ELAPSED_W-1:0] elapsed;
    logic [SPEED_W-1:0]   eff_speed;
    logic [SEC_W-1:0]     seconds;
    flags_t               flags;
  } snap_t;

  typedef struct packed {
    logic [VAL_W-1:0] hi;
    logic [VAL_W-1:0] lo;
    logic             colon;
    flags_t           flags;
  } tres_t;

  typedef struct packed {
    logic             strike_led_two;
    logic             strike_led_one;
    logic             colon_lit;
    logic [SEG_W-1:0] digit_3;
    logic [SEG_W-1:0] digit_2;
    logic [SEG_W-1:0] digit_1;
    logic [SEG_W-1:0] digit_0;
  } out_beat_t;

  function automatic logic [SEG_W-1:0] seg7(input logic [DIG_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 7'b0111111;
      4'd1:    s = 7'b0000110;
      4'd2:    s = 7'b1011011;
      4'd3:    s = 7'b1001111;
      4'd4:    s = 7'b1100110;
      4'd5:    s = 7'b1101101;
      4'd6:    s = 7'b1111101;
      4'd7:    s = 7'b0000111;
      4'd8:    s = 7'b1111111;
      4'd9:    s = 7'b1101111;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

/* sv/scd_front.sv */
`timescale 1ns / 1ps
// Timer state registers and the snapshot register that feeds the time pipeline.
module scd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  scd_pkg::mode_e   mode_i,
  input  scd_pkg::in_beat_t beat_i,
  input  logic             load_i,
  output logic             emit_o,
  output scd_pkg::snap_t   snap_o
);
  import scd_pkg::*;

  logic [SEC_W-1:0]     seconds_q, seconds_d;
  logic [SPEED_W-1:0]   speed_q, speed_d;
  logic [STRIKE_W-1:0]  strikes_q, strikes_d;
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic [BLINK_W-1:0]   blink_q, blink_d;
  logic                 is_tick;
  logic                 blink_lvl;
  snap_t                snap_q, snap_d;

  always_comb begin
    seconds_d = seconds_q;
    speed_d   = speed_q;
    strikes_d = strikes_q;
    elapsed_d = elapsed_q;
    blink_d   = blink_q;
    is_tick   = 1'b0;
    case (mode_i)
      MODE_LOAD: begin
        seconds_d = beat_i.load_seconds;
        speed_d   = beat_i.load_speed;
        strikes_d = beat_i.load_strikes;
        elapsed_d = '0;
      end
      MODE_START: begin
        elapsed_d = '0;
      end
      MODE_TICK: begin
        is_tick = 1'b1;
        if (elapsed_q != '1) begin
          elapsed_d = elapsed_q + 1'b1;
        end
        if (blink_q == BLINK_W'(BLINK_PERIOD_MS - 1)) begin
          blink_d = '0;
        end else begin
          blink_d = blink_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seconds_q <= NO_TIME;
      speed_q   <= '0;
      strikes_q <= '0;
      elapsed_q <= '0;
      blink_q   <= '0;
    end else if (accept_i) begin
      seconds_q <= seconds_d;
      speed_q   <= speed_d;
      strikes_q <= strikes_d;
      elapsed_q <= elapsed_d;
      blink_q   <= blink_d;
    end
  end

  // LEDs blink in the first half of the period
  assign blink_lvl = blink_d < BLINK_W'(BLINK_PERIOD_MS / 2);

  always_comb begin
    snap_d.elapsed        = elapsed_d;
    snap_d.eff_speed      = beat_i.running ? speed_q : '0;
    snap_d.seconds        = seconds_q;
    snap_d.flags.notime   = seconds_q == NO_TIME;
    snap_d.flags.exploded = beat_i.exploded;
    snap_d.flags.led1     = !beat_i.exploded &&
                            ((strikes_q == STRIKE_W'(1)) ||
                             ((strikes_q >= STRIKE_W'(2)) && blink_lvl));
    snap_d.flags.led2     = !beat_i.exploded && (strikes_q >= STRIKE_W'(2)) && blink_lvl;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      snap_q <= snap_d;
    end
  end

  assign emit_o = accept_i && is_tick && beat_i.active;
  assign snap_o = snap_q;

endmodule

/* sv/scd_time.sv */
`timescale 1ns / 1ps
// Pipeline from elapsed ms and speed to the two display values and the colon.
module scd_time (
  input  logic                           clk_i,
  input  logic [scd_pkg::TIME_STAGES-1:0] en_i,
  input  scd_pkg::snap_t                 snap_i,
  output scd_pkg::tres_t                 res_o
);
  import scd_pkg::*;

  flags_t flg_q [TIME_STAGES];

  // stage 0: product and total centis
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [TOTAL_W-1:0] total0_q, total0_d;
  // stage 1: split divide by 5
  logic [Q_W-1:0]     q;
  logic [QH_W-1:0]    qh;
  logic [QL_W-1:0]    ql;
  logic [A_W-1:0]     a_q, a_d;
  logic [S_W-1:0]     s_q, s_d;
  logic [TOTAL_W-1:0] total1_q;
  // stage 2
  logic [S_W+RCP5_SH-1:0] s_m;
  logic [SD_W-1:0]    sd_q, sd_d;
  logic [A_W-1:0]     a2_q;
  logic [TOTAL_W-1:0] total2_q;
  // stage 3: elapsed centis
  logic [CE_W-1:0]    ce_q, ce_d;
  logic [TOTAL_W-1:0] total3_q;
  // stage 4: remaining centis and colon fold
  logic [TOTAL_W-1:0] left_q, left_d;
  logic [X_W-1:0]     x_q, x_d;
  // stage 5
  logic [TOTAL_W+RCPL_SH-1:0] left_m;
  logic [X_W+RCPX_SH-1:0]     x_m;
  logic [C_W-1:0]     c_q, c_d;
  logic [Q100X_W-1:0] q100_q, q100_d;
  logic [TOTAL_W-1:0] left5_q;
  logic [X_W-1:0]     x5_q;
  // stage 6
  logic [C_W+RCPM_SH-1:0] c_m;
  logic [TOTAL_W-1:0] lo_full;
  logic [X_W-1:0]     xmod;
  logic [VAL_W-1:0]   los_q, los_d;
  logic [MIN_W-1:0]   min_q, min_d;
  logic               colon6_q, colon6_d;
  logic               small_q, small_d;
  logic [C_W-1:0]     c6_q;
  // stage 7
  logic [C_W-1:0]     sec_full;
  logic [VAL_W-1:0]   hi_q, hi_d, lo_q, lo_d;
  logic               colon7_q;

  assign prod_d   = PROD_W'(snap_i.elapsed) * PROD_W'(snap_i.eff_speed);
  assign total0_d = TOTAL_W'(snap_i.seconds) * TOTAL_W'(CS_PER_S);

  // q = qh*2^20 + ql and 2^20 = 5*QL_DIV5 + 1
  assign q   = prod_q[PROD_W-1:PRE_SH];
  assign qh  = q[Q_W-1:QL_W];
  assign ql  = q[QL_W-1:0];
  assign a_d = A_W'(qh) * A_W'(QL_DIV5);
  assign s_d = S_W'(qh) + S_W'(ql);

  assign s_m  = (S_W+RCP5_SH)'(s_q) * (S_W+RCP5_SH)'(RCP5);
  assign sd_d = s_m[RCP5_SH +: SD_W];

  assign ce_d = CE_W'(a2_q) + CE_W'(sd_q);

  assign left_d = (CMP_W'(ce_q) >= CMP_W'(total3_q)) ? '0 :
                  TOTAL_W'(CMP_W'(total3_q) - CMP_W'(ce_q));
  assign x_d    = X_W'(ce_q[CE_W-1:CL_W]) * X_W'(FOLD) + X_W'(ce_q[CL_W-1:0]);

  assign left_m = (TOTAL_W+RCPL_SH)'(left_q) * (TOTAL_W+RCPL_SH)'(RCPL);
  assign c_d    = left_m[RCPL_SH +: C_W];
  assign x_m    = (X_W+RCPX_SH)'(x_q) * (X_W+RCPX_SH)'(RCPX);
  assign q100_d = x_m[RCPX_SH +: Q100X_W];

  assign lo_full  = left5_q - TOTAL_W'(c_q) * TOTAL_W'(CS_PER_S);
  assign los_d    = lo_full[VAL_W-1:0];
  assign c_m      = (C_W+RCPM_SH)'(c_q) * (C_W+RCPM_SH)'(RCPM);
  assign min_d    = c_m[RCPM_SH +: MIN_W];
  assign xmod     = x5_q - X_W'(q100_q) * X_W'(CS_PER_S);
  assign colon6_d = xmod >= X_W'(COLON_HALF);
  assign small_d  = left5_q < TOTAL_W'(SS_LIMIT);

  assign sec_full = c6_q - C_W'(min_q) * C_W'(S_PER_MIN);
  always_comb begin
    if (small_q) begin
      hi_d = c6_q[VAL_W-1:0];
      lo_d = los_q;
    end else begin
      hi_d = (min_q > MIN_W'(MAX_MIN)) ? VAL_W'(MAX_MIN) : min_q[VAL_W-1:0];
      lo_d = sec_full[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      flg_q[0] <= snap_i.flags;
      prod_q   <= prod_d;
      total0_q <= total0_d;
    end
    for (int k = 1; k < TIME_STAGES; k++) begin
      if (en_i[k]) begin
        flg_q[k] <= flg_q[k-1];
      end
    end
    if (en_i[1]) begin
      a_q      <= a_d;
      s_q      <= s_d;
      total1_q <= total0_q;
    end
    if (en_i[2]) begin
      sd_q     <= sd_d;
      a2_q     <= a_q;
      total2_q <= total1_q;
    end
    if (en_i[3]) begin
      ce_q     <= ce_d;
      total3_q <= total2_q;
    end
    if (en_i[4]) begin
      left_q <= left_d;
      x_q    <= x_d;
    end
    if (en_i[5]) begin
      c_q     <= c_d;
      q100_q  <= q100_d;
      left5_q <= left_q;
      x5_q    <= x_q;
    end
    if (en_i[6]) begin
      los_q    <= los_d;
      min_q    <= min_d;
      colon6_q <= colon6_d;
      small_q  <= small_d;
      c6_q     <= c_q;
    end
    if (en_i[7]) begin
      hi_q     <= hi_d;
      lo_q     <= lo_d;
      colon7_q <= colon6_q;
    end
  end

  assign res_o.hi    = hi_q;
  assign res_o.lo    = lo_q;
  assign res_o.colon = colon7_q;
  assign res_o.flags = flg_q[TIME_STAGES-1];

endmodule

/* sv/scd_disp.sv */
`timescale 1ns / 1ps
// Digit split, segment encoding and the output register.
module scd_disp (
  input  logic               clk_i,
  input  logic               en_i,
  input  scd_pkg::tres_t     res_i,
  output scd_pkg::out_beat_t beat_o
);
  import scd_pkg::*;

  logic [DIV10_W-1:0] hi_m, lo_m;
  logic [DIG_W-1:0]   hi_t, hi_u, lo_t, lo_u;
  logic [VAL_W-1:0]   hi_r, lo_r;
  out_beat_t          beat_q, beat_d;

  assign hi_m = DIV10_W'(res_i.hi) * DIV10_W'(DIV10_RCP);
  assign lo_m = DIV10_W'(res_i.lo) * DIV10_W'(DIV10_RCP);
  assign hi_t = hi_m[DIV10_SH +: DIG_W];
  assign lo_t = lo_m[DIV10_SH +: DIG_W];
  assign hi_r = res_i.hi - VAL_W'(hi_t) * VAL_W'(RADIX);
  assign lo_r = res_i.lo - VAL_W'(lo_t) * VAL_W'(RADIX);
  assign hi_u = hi_r[DIG_W-1:0];
  assign lo_u = lo_r[DIG_W-1:0];

  always_comb begin
    beat_d.strike_led_one = res_i.flags.led1;
    beat_d.strike_led_two = res_i.flags.led2;
    if (res_i.flags.exploded) begin
      beat_d.digit_0   = '0;
      beat_d.digit_1   = '0;
      beat_d.digit_2   = '0;
      beat_d.digit_3   = '0;
      beat_d.colon_lit = 1'b0;
    end else if (res_i.flags.notime) begin
      beat_d.digit_0   = SEG_DASH;
      beat_d.digit_1   = SEG_DASH;
      beat_d.digit_2   = SEG_DASH;
      beat_d.digit_3   = SEG_DASH;
      beat_d.colon_lit = 1'b1;
    end else begin
      beat_d.digit_0   = seg7(hi_t);
      beat_d.digit_1   = seg7(hi_u);
      beat_d.digit_2   = seg7(lo_t);
      beat_d.digit_3   = seg7(lo_u);
      beat_d.colon_lit = res_i.colon;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      beat_q <= beat_d;
    end
  end

  assign beat_o = beat_q;

endmodule

/* sv/scaled_countdown_seven_segment_unit.sv */
`timescale 1ns / 1ps
// Top level of the countdown timer seven-segment display engine.
//
// Input stream: one beat per item. tuser carries the item kind: tick, load
// (seconds, speed, strikes; clears the elapsed counter) or start (clears the
// elapsed counter only). Timer state updates at the beat itself, so items
// may follow each other in every cycle while s_axis_tready is high.
// Output stream: one beat for each tick taken while active is high; load,
// start, inactive ticks and the unused kind give no beat.
// Pipeline: a display beat passes a 10-deep register chain (snapshot, 8
// time stages, output) before it shows on the master side.
// Throughput: one item per cycle, limited by nothing but the output side.
// Each stage holds only while the stage after it is full and stalled, so
// empty stages fill up under backpressure; tready drops once every stage
// holds a beat and m_axis_tready is low.
// Reset: no time set (dashes shown), speed 0, no strikes, counters cleared,
// pipeline empty.
module scaled_countdown_seven_segment_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [15:0] load_seconds, [31:16] load_speed, [39:32] load_strikes,
  // [40] active, [41] running, [42] exploded, [47:43] zero
  input  logic [scd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [1:0] mode
  input  logic [scd_pkg::MODE_W-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [6:0] digit_0, [13:7] digit_1, [20:14] digit_2, [27:21] digit_3,
  // [28] colon_lit, [29] strike_led_one, [30] strike_led_two, [31] zero
  output logic [scd_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import scd_pkg::*;

  localparam int IN_BITS  = $bits(in_beat_t);
  localparam int OUT_BITS = $bits(out_beat_t);

  logic [PIPE_STAGES-1:0] vld_q;
  logic [PIPE_STAGES-1:0] en;
  logic                   accept;
  logic                   emit;
  in_beat_t               in_beat;
  mode_e                  mode;
  snap_t                  snap;
  tres_t                  tres;
  out_beat_t              out_beat;

  always_comb begin
    en[PIPE_STAGES-1] = !vld_q[PIPE_STAGES-1] || m_axis_tready;
    for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  assign s_axis_tready = en[0];
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_beat       = in_beat_t'(s_axis_tdata[IN_BITS-1:0]);
  assign mode          = mode_e'(s_axis_tuser);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= emit;
      end
      for (int i = 1; i < PIPE_STAGES; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  scd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .mode_i   (mode),
    .beat_i   (in_beat),
    .load_i   (en[0]),
    .emit_o   (emit),
    .snap_o   (snap)
  );

  scd_time u_time (
    .clk_i  (clk_i),
    .en_i   (en[TIME_STAGES:1]),
    .snap_i (snap),
    .res_o  (tres)
  );

  scd_disp u_disp (
    .clk_i  (clk_i),
    .en_i   (en[PIPE_STAGES-1]),
    .res_i  (tres),
    .beat_o (out_beat)
  );

  assign m_axis_tvalid = vld_q[PIPE_STAGES-1];
  assign m_axis_tdata  = {(OUT_DATA_W - OUT_BITS)'(0), out_beat};

endmodule
